@@ sv/qag_pkg.sv @@
// shared types and constants for the attitude and g-load pipeline
`default_nettype none
package qag_pkg;

  // width of the quaternion-derived vector components
  localparam int VW = 35;
  // cordic datapath width, holds the normalized vector plus gain growth
  localparam int CW = 58;
  // bit that the normalized vector magnitude must reach
  localparam int NORM_BIT = 52;
  localparam int NORM_STEPS = 6;
  localparam int CORDIC_STEPS = 31;
  localparam int CORDIC_LAT = 1 + NORM_STEPS + 1 + CORDIC_STEPS;

  localparam int S_W = 21;
  localparam int PITCH_NW = 40;
  localparam int PITCH_RW = 20;
  localparam int G_NW = 32;
  localparam int G_RW = 16;

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic signed [VW-1:0] SIN_LIM = 35'sd1000000;
  localparam logic [PITCH_NW-1:0] UNIT_SQ = 40'd1000000000000;

  // atan(2^-i) as a 32-bit turn fraction
  localparam logic [31:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1
  };

  typedef struct packed {
    logic                 vld;
    logic                 att;
    logic signed [VW-1:0] s;
    logic signed [VW-1:0] hx;
    logic signed [VW-1:0] hy;
    logic signed [VW-1:0] rx;
    logic signed [VW-1:0] ry;
  } att_t;

  typedef struct packed {
    logic        att;
    logic        gok;
    logic [15:0] g;
  } tail_t;

endpackage
`default_nettype wire

@@ sv/qag_isqrt.sv @@
// pipelined integer square root, one result bit per stage, remainder kept
`default_nettype none
module qag_isqrt #(
  parameter int NW = 32,
  parameter int RW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          vld_i,
  input  wire logic [NW-1:0] n_i,
  output logic               vld_o,
  output logic [RW-1:0]      root_o,
  output logic [NW-1:0]      rem_o
);

  localparam int TW = 2 * RW + 1;
  localparam int MW = (NW + 1 > TW) ? NW + 1 : TW;

  logic          v_r   [0:RW-1];
  logic [NW-1:0] rem_r [0:RW-1];
  logic [RW-1:0] res_r [0:RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic          v_in;
    logic [NW-1:0] rem_in;
    logic [RW-1:0] res_in;
    logic [MW-1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign v_in   = vld_i;
      assign rem_in = n_i;
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
    end

    // (res + 2^b)^2 - res^2
    assign trial = (MW'(res_in) << (B + 1)) | (MW'(1) << (2 * B));
    assign take  = MW'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= take ? NW'(MW'(rem_in) - trial) : rem_in;
      res_r[k] <= take ? (res_in | (RW'(1) << B)) : res_in;
    end
  end

  assign vld_o  = v_r[RW-1];
  assign root_o = res_r[RW-1];
  assign rem_o  = rem_r[RW-1];

endmodule
`default_nettype wire

@@ sv/qag_cordic.sv @@
// pipelined atan2: magnitude normalization then cordic vectoring steps
`default_nettype none
module qag_cordic import qag_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 vld_i,
  input  wire logic signed [VW-1:0] x_i,
  input  wire logic signed [VW-1:0] y_i,
  output logic                      vld_o,
  output logic [31:0]               z_o
);

  logic                nv_r [0:NORM_STEPS];
  logic                nz_r [0:NORM_STEPS];
  logic signed [CW-1:0] nx_r [0:NORM_STEPS];
  logic signed [CW-1:0] ny_r [0:NORM_STEPS];
  logic [NORM_BIT-1:0] nm_r [0:NORM_STEPS];

  logic                cv_r [0:CORDIC_STEPS];
  logic                cz0_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] cx_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] cy_r [0:CORDIC_STEPS];
  logic [31:0]         cz_r [0:CORDIC_STEPS];

  logic [VW-1:0] ax;
  logic [VW-1:0] ay;

  assign ax = x_i[VW-1] ? $unsigned(-x_i) : $unsigned(x_i);
  assign ay = y_i[VW-1] ? $unsigned(-y_i) : $unsigned(y_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r[0] <= 1'b0;
    end else begin
      nv_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    nz_r[0] <= (x_i == '0) && (y_i == '0);
    nx_r[0] <= CW'(x_i);
    ny_r[0] <= CW'(y_i);
    nm_r[0] <= NORM_BIT'(ax | ay);
  end

  // binary search for the left shift that keeps the magnitude below the target bit
  for (genvar j = 1; j <= NORM_STEPS; j++) begin : g_norm
    localparam int SH = 1 << (NORM_STEPS - j);
    logic sh;

    assign sh = (nm_r[j-1] >> (NORM_BIT - SH)) == '0;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nv_r[j] <= 1'b0;
      end else begin
        nv_r[j] <= nv_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      nz_r[j] <= nz_r[j-1];
      nx_r[j] <= sh ? (nx_r[j-1] <<< SH) : nx_r[j-1];
      ny_r[j] <= sh ? (ny_r[j-1] <<< SH) : ny_r[j-1];
      nm_r[j] <= sh ? (nm_r[j-1] << SH) : nm_r[j-1];
    end
  end

  // last doubling crosses the target bit, then fold into the right half plane
  logic signed [CW-1:0] x2;
  logic signed [CW-1:0] y2;

  assign x2 = nx_r[NORM_STEPS] <<< 1;
  assign y2 = ny_r[NORM_STEPS] <<< 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else begin
      cv_r[0] <= nv_r[NORM_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    cz0_r[0] <= nz_r[NORM_STEPS];
    if (x2 < 0) begin
      cx_r[0] <= -x2;
      cy_r[0] <= -y2;
      cz_r[0] <= HALF_TURN;
    end else begin
      cx_r[0] <= x2;
      cy_r[0] <= y2;
      cz_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    assign dx = cy_r[i] >>> i;
    assign dy = cx_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else begin
        cv_r[i+1] <= cv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      cz0_r[i+1] <= cz0_r[i];
      if (cy_r[i] > 0) begin
        cx_r[i+1] <= cx_r[i] + dx;
        cy_r[i+1] <= cy_r[i] - dy;
        cz_r[i+1] <= cz_r[i] + ATAN_TURN[i];
      end else begin
        cx_r[i+1] <= cx_r[i] - dx;
        cy_r[i+1] <= cy_r[i] + dy;
        cz_r[i+1] <= cz_r[i] - ATAN_TURN[i];
      end
    end
  end

  assign vld_o = cv_r[CORDIC_STEPS];
  assign z_o   = cz0_r[CORDIC_STEPS] ? '0 : cz_r[CORDIC_STEPS];

endmodule
`default_nettype wire

@@ sv/quaternion_attitude_and_gload.sv @@
// top level: quaternion attitude angles and acceleration magnitude
//
// A sample is transferred at each rising edge where start is high and busy
// is low. busy stays low: the pipeline takes one sample every cycle.
// Every sample gives one result, marked by out_valid for exactly one
// cycle; results leave in sample order. On the pitch path a sample passes
// 4 product/sum stages, a 20-stage square root for the cosine of pitch,
// and a 39-stage atan2 unit (one input stage, 6 normalization stages, one
// fold stage, 31 cordic steps), plus an output stage.
// Heading and roll vectors are delayed to enter their atan2 units alongside
// pitch; the g-load uses a 16-stage square root and one rounding stage.
// Angles are binary angles with 2^ANGLE_BITS steps per turn, low 16 bits
// shown. Invalid attitude or g-load gives zero fields.
// Synchronous reset clears all valid bits in the pipeline; samples in
// flight are dropped. The receiver cannot stall: results are not held.
`default_nettype none
module quaternion_attitude_and_gload import qag_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_quat_present,
  input  wire logic signed [15:0] in_q_zero,
  input  wire logic signed [15:0] in_q_one,
  input  wire logic signed [15:0] in_q_two,
  input  wire logic signed [15:0] in_q_three,
  input  wire logic               in_accel_present,
  input  wire logic signed [15:0] in_accel_x,
  input  wire logic signed [15:0] in_accel_y,
  input  wire logic signed [15:0] in_accel_z,
  output logic                    out_valid,
  output logic                    out_attitude_valid,
  output logic signed [15:0]      out_pitch_angle,
  output logic [15:0]             out_heading_angle,
  output logic signed [15:0]      out_bank_angle,
  output logic                    out_gload_valid,
  output logic [15:0]             out_gload_milli
);

  localparam int RSH = 32 - ANGLE_BITS;
  localparam logic [31:0] RND = 32'(1) << (31 - ANGLE_BITS);
  localparam int AD_N = PITCH_RW + 3;
  localparam int GD_N = 5;

  assign busy = 1'b0;

  // products
  logic               v1_r;
  logic               aq1_r;
  logic               ag1_r;
  logic signed [31:0] p00_r, p11_r, p22_r, p33_r;
  logic signed [31:0] p01_r, p02_r, p03_r, p12_r, p13_r, p23_r;
  logic signed [31:0] sx_r, sy_r, sz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    aq1_r <= in_quat_present;
    ag1_r <= in_accel_present;
    p00_r <= in_q_zero * in_q_zero;
    p11_r <= in_q_one * in_q_one;
    p22_r <= in_q_two * in_q_two;
    p33_r <= in_q_three * in_q_three;
    p01_r <= in_q_zero * in_q_one;
    p02_r <= in_q_zero * in_q_two;
    p03_r <= in_q_zero * in_q_three;
    p12_r <= in_q_one * in_q_two;
    p13_r <= in_q_one * in_q_three;
    p23_r <= in_q_two * in_q_three;
    sx_r  <= in_accel_x * in_accel_x;
    sy_r  <= in_accel_y * in_accel_y;
    sz_r  <= in_accel_z * in_accel_z;
  end

  // sums, then the attitude bundle travels down a delay line
  att_t ad_nxt;
  att_t ad_r [0:AD_N-1];

  always_comb begin
    ad_nxt.vld = v1_r;
    ad_nxt.s   = (VW'(p13_r) - VW'(p02_r)) <<< 1;
    ad_nxt.hx  = VW'(p33_r) - VW'(p00_r) - VW'(p11_r) + VW'(p22_r);
    ad_nxt.hy  = (VW'(p12_r) + VW'(p03_r)) <<< 1;
    ad_nxt.rx  = VW'(p33_r) + VW'(p00_r) - VW'(p11_r) - VW'(p22_r);
    ad_nxt.ry  = (VW'(p01_r) + VW'(p23_r)) <<< 1;
    ad_nxt.att = aq1_r && (ad_nxt.s <= SIN_LIM) && (ad_nxt.s >= -SIN_LIM);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < AD_N; k++) begin
        ad_r[k] <= '0;
      end
    end else begin
      ad_r[0] <= ad_nxt;
      for (int k = 1; k < AD_N; k++) begin
        ad_r[k] <= ad_r[k-1];
      end
    end
  end

  // cosine of pitch: sqrt(1e12 - s^2)
  logic signed [S_W-1:0]   s21;
  logic signed [2*S_W-1:0] sqw;
  logic [PITCH_NW-1:0]     sq3_r;
  logic [PITCH_NW-1:0]     n4_r;

  assign s21 = ad_r[0].att ? S_W'(ad_r[0].s) : '0;
  assign sqw = s21 * s21;

  always_ff @(posedge clk) begin
    sq3_r <= PITCH_NW'($unsigned(sqw));
    n4_r  <= UNIT_SQ - sq3_r;
  end

  logic                pc_vld;
  logic [PITCH_RW-1:0] pc_root;

  qag_isqrt #(
    .NW (PITCH_NW),
    .RW (PITCH_RW)
  ) u_pitch_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (ad_r[2].vld),
    .n_i    (n4_r),
    .vld_o  (pc_vld),
    .root_o (pc_root),
    .rem_o  ()
  );

  // g-load magnitude
  logic            gv2_r;
  logic [G_NW-1:0] gn2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gv2_r <= 1'b0;
    end else begin
      gv2_r <= v1_r && ag1_r;
    end
  end

  always_ff @(posedge clk) begin
    gn2_r <= G_NW'($unsigned(sx_r)) + G_NW'($unsigned(sy_r)) + G_NW'($unsigned(sz_r));
  end

  logic            gs_vld;
  logic [G_RW-1:0] gs_root;
  logic [G_NW-1:0] gs_rem;

  qag_isqrt #(
    .NW (G_NW),
    .RW (G_RW)
  ) u_g_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (gv2_r),
    .n_i    (gn2_r),
    .vld_o  (gs_vld),
    .root_o (gs_root),
    .rem_o  (gs_rem)
  );

  // round half up: bump when remainder exceeds the root
  tail_t g19_nxt;
  tail_t g19_r;
  tail_t gd_r [0:GD_N-1];

  always_comb begin
    g19_nxt.att = 1'b0;
    g19_nxt.gok = gs_vld;
    g19_nxt.g   = (gs_rem > G_NW'(gs_root)) ? gs_root + 16'd1 : gs_root;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g19_r <= '0;
      for (int k = 0; k < GD_N; k++) begin
        gd_r[k] <= '0;
      end
    end else begin
      g19_r   <= g19_nxt;
      gd_r[0] <= g19_r;
      for (int k = 1; k < GD_N; k++) begin
        gd_r[k] <= gd_r[k-1];
      end
    end
  end

  // three atan2 units in lockstep
  logic        vp, vh, vr;
  logic [31:0] zp, zh, zr;

  qag_cordic u_pitch_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (pc_vld),
    .x_i   ($signed(VW'(pc_root))),
    .y_i   (ad_r[AD_N-1].s),
    .vld_o (vp),
    .z_o   (zp)
  );

  qag_cordic u_head_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (ad_r[AD_N-1].vld),
    .x_i   (ad_r[AD_N-1].hx),
    .y_i   (ad_r[AD_N-1].hy),
    .vld_o (vh),
    .z_o   (zh)
  );

  qag_cordic u_roll_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (ad_r[AD_N-1].vld),
    .x_i   (ad_r[AD_N-1].rx),
    .y_i   (ad_r[AD_N-1].ry),
    .vld_o (vr),
    .z_o   (zr)
  );

  tail_t td_nxt;
  tail_t td_r [0:CORDIC_LAT-1];

  always_comb begin
    td_nxt     = gd_r[GD_N-1];
    td_nxt.att = ad_r[AD_N-1].att;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CORDIC_LAT; k++) begin
        td_r[k] <= '0;
      end
    end else begin
      td_r[0] <= td_nxt;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        td_r[k] <= td_r[k-1];
      end
    end
  end

  // round to the angle resolution
  logic [31:0]        zp_rnd, zh_rnd, zr_rnd;
  logic signed [31:0] tp, tr;
  logic [31:0]        th;
  logic               att_f;

  assign att_f  = td_r[CORDIC_LAT-1].att;
  assign zp_rnd = zp + RND;
  assign zh_rnd = zh + HALF_TURN + RND;
  assign zr_rnd = zr + RND;
  assign tp     = $signed(zp_rnd) >>> RSH;
  assign tr     = $signed(zr_rnd) >>> RSH;
  assign th     = zh_rnd >> RSH;

  logic               out_valid_r;
  logic               att_r;
  logic signed [15:0] pitch_r;
  logic [15:0]        head_r;
  logic signed [15:0] bank_r;
  logic               gok_r;
  logic [15:0]        g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vp && vh && vr;
    end
  end

  always_ff @(posedge clk) begin
    att_r   <= att_f;
    pitch_r <= att_f ? tp[15:0] : '0;
    head_r  <= att_f ? th[15:0] : '0;
    bank_r  <= att_f ? tr[15:0] : '0;
    gok_r   <= td_r[CORDIC_LAT-1].gok;
    g_r     <= td_r[CORDIC_LAT-1].gok ? td_r[CORDIC_LAT-1].g : '0;
  end

  assign out_valid          = out_valid_r;
  assign out_attitude_valid = att_r;
  assign out_pitch_angle    = pitch_r;
  assign out_heading_angle  = head_r;
  assign out_bank_angle     = bank_r;
  assign out_gload_valid    = gok_r;
  assign out_gload_milli    = g_r;

endmodule
`default_nettype wire

@@ tb/quaternion_attitude_and_gload_tb.sv @@
// self-checking testbench for the quaternion attitude and g-load pipeline
`default_nettype none
module quaternion_attitude_and_gload_tb;
  import qag_pkg::*;

  localparam int ANG_BITS = 16;
  localparam int N_RANDOM = 530;

  typedef struct {
    bit               quat_ok;
    bit signed [15:0] q0, q1, q2, q3;
    bit               acc_ok;
    bit signed [15:0] ax, ay, az;
  } sample_t;

  typedef struct {
    bit        att_ok;
    bit [15:0] pitch, head, bank;
    bit        g_ok;
    bit [15:0] gload;
  } attitude_t;

  localparam bit [31:0] ATAN_STEP [0:30] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_quat_present = 1'b0;
  logic signed [15:0] in_q_zero = '0, in_q_one = '0, in_q_two = '0, in_q_three = '0;
  logic in_accel_present = 1'b0;
  logic signed [15:0] in_accel_x = '0, in_accel_y = '0, in_accel_z = '0;
  logic busy, out_valid, out_attitude_valid, out_gload_valid;
  logic signed [15:0] out_pitch_angle, out_bank_angle;
  logic [15:0] out_heading_angle, out_gload_milli;

  quaternion_attitude_and_gload #(.ANGLE_BITS(ANG_BITS)) u_top (
    .clk, .rst_n, .start, .busy,
    .in_quat_present, .in_q_zero, .in_q_one, .in_q_two, .in_q_three,
    .in_accel_present, .in_accel_x, .in_accel_y, .in_accel_z,
    .out_valid, .out_attitude_valid, .out_pitch_angle, .out_heading_angle,
    .out_bank_angle, .out_gload_valid, .out_gload_milli
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_t   sample_q[$];
  attitude_t attitude_q[$];
  sample_t   on_bus;
  int        idle_pct = 26;
  int        n_mismatch = 0;
  bit        gen_done = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // vectoring cordic, result as a 32-bit turn fraction
  function automatic bit [31:0] turn_of(longint y, longint x);
    longint lim, dx, dy;
    bit [31:0] z;
    lim = 64'sd1 <<< 52;
    z = 0;
    if (x == 0 && y == 0) return 0;
    while (x < lim && x > -lim && y < lim && y > -lim) begin
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 31; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_STEP[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_STEP[i];
      end
    end
    return z;
  endfunction

  function automatic bit [31:0] to_angle(bit [31:0] z);
    z += 32'd1 << (31 - ANG_BITS);
    return z >> (32 - ANG_BITS);
  endfunction

  function automatic bit [15:0] wrap_signed(bit [31:0] a);
    longint v;
    v = longint'(a);
    if (a[ANG_BITS-1]) v -= 64'sd1 <<< ANG_BITS;
    return v[15:0];
  endfunction

  function automatic attitude_t predict_attitude(sample_t s);
    attitude_t r;
    longint q0, q1, q2, q3, sp, cp, hx, hy, rx, ry, ax, ay, az;
    longint unsigned n, g;
    r = '{default: 0};
    if (s.quat_ok) begin
      q0 = longint'(s.q0); q1 = longint'(s.q1);
      q2 = longint'(s.q2); q3 = longint'(s.q3);
      sp = 2 * (q3 * q1 - q0 * q2);
      if (sp <= 1000000 && sp >= -1000000) begin
        cp = longint'(int_sqrt(64'd1000000000000 - sp * sp));
        hx = q3 * q3 - q0 * q0 - q1 * q1 + q2 * q2;
        hy = 2 * (q1 * q2 + q3 * q0);
        rx = q3 * q3 + q0 * q0 - q1 * q1 - q2 * q2;
        ry = 2 * (q0 * q1 + q3 * q2);
        r.att_ok = 1;
        r.pitch = wrap_signed(to_angle(turn_of(sp, cp)));
        r.head = 16'(to_angle(32'h8000_0000 + turn_of(hy, hx)));
        r.bank = wrap_signed(to_angle(turn_of(ry, rx)));
      end
    end
    if (s.acc_ok) begin
      ax = longint'(s.ax); ay = longint'(s.ay); az = longint'(s.az);
      n = ax * ax + ay * ay + az * az;
      g = int_sqrt(n);
      if (n - g * g > g) g++;
      r.g_ok = 1;
      r.gload = g[15:0];
    end
    return r;
  endfunction

  // driver: a transfer happens where start is high and busy is low
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) attitude_q.push_back(predict_attitude(on_bus));
      if (!start || !busy) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          on_bus = sample_q.pop_front();
          start <= 1'b1;
          in_quat_present <= on_bus.quat_ok;
          in_q_zero <= on_bus.q0;
          in_q_one <= on_bus.q1;
          in_q_two <= on_bus.q2;
          in_q_three <= on_bus.q3;
          in_accel_present <= on_bus.acc_ok;
          in_accel_x <= on_bus.ax;
          in_accel_y <= on_bus.ay;
          in_accel_z <= on_bus.az;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    attitude_t exp_r;
    if (rst_n && out_valid) begin
      if (attitude_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result at %0t", $time);
      end else begin
        exp_r = attitude_q.pop_front();
        if (out_attitude_valid !== exp_r.att_ok || out_pitch_angle !== exp_r.pitch ||
            out_heading_angle !== exp_r.head || out_bank_angle !== exp_r.bank ||
            out_gload_valid !== exp_r.g_ok || out_gload_milli !== exp_r.gload) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"mismatch at %0t: exp att=%0b p=%h h=%h b=%h g=%0b %0d",
                      "  got att=%0b p=%h h=%h b=%h g=%0b %0d"},
                     $time, exp_r.att_ok, exp_r.pitch, exp_r.head, exp_r.bank, exp_r.g_ok,
                     exp_r.gload, out_attitude_valid, out_pitch_angle, out_heading_angle,
                     out_bank_angle, out_gload_valid, out_gload_milli);
        end
      end
    end
  end

  function automatic sample_t mk(bit qp, int a, int b, int c, int d,
                                 bit ap, int x, int y, int z);
    sample_t s;
    s.quat_ok = qp; s.q0 = 16'(a); s.q1 = 16'(b); s.q2 = 16'(c); s.q3 = 16'(d);
    s.acc_ok = ap; s.ax = 16'(x); s.ay = 16'(y); s.az = 16'(z);
    return s;
  endfunction

  function automatic int rnd_comp(int mode);
    case (mode)
      0: return $urandom_range(2000) - 1000;
      1: return $signed(16'($urandom()));
      2: return $urandom_range(40) - 20;
      default: begin
        case ($urandom_range(3))
          0: return -32768;
          1: return 32767;
          2: return 0;
          default: return 1000;
        endcase
      end
    endcase
  endfunction

  initial begin
    sample_t s;
    int qm, am;
    // directed: identity, zero vector, pitch at both limits and just beyond
    sample_q.push_back(mk(1, 0, 0, 0, 1000, 1, 0, 0, 1000));
    sample_q.push_back(mk(1, 0, 0, 0, 0, 1, 0, 0, 0));
    sample_q.push_back(mk(1, 0, 500, 0, 1000, 1, 1, -1, 1));
    sample_q.push_back(mk(1, 0, -500, 0, 1000, 1, -32768, -32768, -32768));
    sample_q.push_back(mk(1, 0, 501, 0, 1000, 1, 32767, 32767, 32767));
    sample_q.push_back(mk(1, 1000, 0, 500, 0, 1, 32767, -32768, 0));
    sample_q.push_back(mk(1, 707, 0, 0, 707, 0, 1234, 5, 6));
    sample_q.push_back(mk(1, 0, 707, 0, 707, 1, 0, 0, -1000));
    sample_q.push_back(mk(1, 0, 0, 707, 707, 1, 577, 577, 577));
    sample_q.push_back(mk(1, 1000, 0, 0, 0, 0, 0, 0, 0));
    sample_q.push_back(mk(1, 0, 1000, 0, 0, 1, 1, 0, 0));
    sample_q.push_back(mk(1, 0, 0, 1000, 0, 1, 0, 1, 1));
    sample_q.push_back(mk(0, 300, 400, 500, 600, 1, -1, -1, -1));
    sample_q.push_back(mk(0, -32768, -32768, -32768, -32768, 0, -32768, 0, 0));
    sample_q.push_back(mk(1, -32768, -32768, -32768, -32768, 1, 0, 0, 32767));
    sample_q.push_back(mk(1, 32767, 32767, 32767, 32767, 1, 2, 1, 0));
    sample_q.push_back(mk(1, 0, 0, 0, -1000, 1, -1000, 0, 0));
    sample_q.push_back(mk(1, 0, 0, 0, 1, 1, 0, -1000, 0));
    sample_q.push_back(mk(1, -1, 0, 0, 0, 1, 100, 100, 100));
    sample_q.push_back(mk(1, 0, -1000, 0, 0, 1, 3, 4, 12));
    for (int k = 0; k < N_RANDOM; k++) begin
      qm = ($urandom_range(99) < 65) ? 0 : $urandom_range(3);
      am = $urandom_range(3);
      s.quat_ok = ($urandom_range(99) < 85);
      s.q0 = 16'(rnd_comp(qm)); s.q1 = 16'(rnd_comp(qm));
      s.q2 = 16'(rnd_comp(qm)); s.q3 = 16'(rnd_comp(qm));
      s.acc_ok = ($urandom_range(99) < 85);
      s.ax = 16'(rnd_comp(am)); s.ay = 16'(rnd_comp(am)); s.az = 16'(rnd_comp(am));
      sample_q.push_back(s);
    end
    gen_done = 1;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // long stretch without gaps in the middle of the run
    wait (sample_q.size() < 350);
    idle_pct = 0;
    wait (sample_q.size() < 200);
    idle_pct = 26;
    do @(posedge clk); while (!(gen_done && sample_q.size() == 0 && !start &&
                                attitude_q.size() == 0));
    repeat (80) @(posedge clk);
    if (n_mismatch == 0 && attitude_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
